// ===== design/dmd_pkg.sv =====
// Shared types and constants for the dual motor drive command block.
// No dependencies; used by every module of the block.
package dmd_pkg;

  // Shared multiplier operand widths
  localparam int unsigned MulAW = 16;
  localparam int unsigned MulBW = 17;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Reciprocal scale: x * floor(2^RecipShift / d) >> RecipShift, then one correction
  localparam int unsigned RecipShift = 16;

  localparam logic [7:0] PctDiv = 8'd100;

  // Command kinds
  localparam logic [1:0] KIND_DRIVE = 2'd0;
  localparam logic [1:0] KIND_ARC   = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Motor selectors
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_TWO  = 2'd1;
  localparam logic [1:0] SEL_BOTH = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_FLOOR_SPEED = 3'd0;
  localparam logic [2:0] REG_TRIM_ONE    = 3'd1;
  localparam logic [2:0] REG_TRIM_TWO    = 3'd2;
  localparam logic [2:0] REG_REVERSE_ONE = 3'd3;
  localparam logic [2:0] REG_REVERSE_TWO = 3'd4;

  typedef struct packed {
    logic [7:0]        floor_speed;
    logic signed [6:0] trim_one;
    logic signed [6:0] trim_two;
    logic              reverse_one;
    logic              reverse_two;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  motor_select;
    logic [15:0] speed;
    logic        direction;
    logic        arc_direction;
    logic [7:0]  arc_radius;
  } item_t;

  // pins: bit0 one A, bit1 one B, bit2 two A, bit3 two B
  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic [3:0] pins;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SELECT,
    ST_TMUL,
    ST_DIV_R,
    ST_DIV_B,
    ST_DIV_C,
    ST_TRIM_FIX,
    ST_MMUL,
    ST_MAP_FIX,
    ST_ARC_MUL,
    ST_ARC_FIX,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_TRIM,
    PH_MAP,
    PH_ARC
  } div_phase_e;

endpackage

// ===== design/dual_motor_drive_command.sv =====
// Dual H-bridge motor command block: one item in at a time, one result item out.
// Each motor runs a trim product and a map product on the shared multiplier, each followed by
// a reciprocal divide pass of three steps. A new item is accepted only after the previous
// result has entered the result slot; a full result slot holds the sequencer and the input.
// Reset: internal duties zero, bridge pins low, config registers zero; the output result
// register is not reset, only its valid flag; no clearing pass.
module dual_motor_drive_command #(
  parameter int unsigned MAX_DUTY         = 255,
  parameter int unsigned ARC_RADIUS_LIMIT = 10,
  parameter int unsigned TRIM_LIMIT       = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  motor_select_i,
  input  logic [15:0] speed_i,
  input  logic        direction_i,
  input  logic        arc_direction_i,
  input  logic [7:0]  arc_radius_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  duty_one_o,
  output logic [7:0]  duty_two_o,
  output logic        one_pin_a_o,
  output logic        one_pin_b_o,
  output logic        two_pin_a_o,
  output logic        two_pin_b_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  dmd_pkg::cfg_t    cfg;
  dmd_pkg::item_t   item;
  dmd_pkg::result_t res;
  dmd_pkg::result_t res_q;
  logic             out_valid_q, out_valid_d;
  logic             idle;
  logic             done_valid;
  logic             done_ack;
  logic             start;

  assign cfg_ready_o = 1'b1;

  dmd_cfg_regs #(
    .TRIM_LIMIT(TRIM_LIMIT)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_addr_i(cfg_addr_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  assign item.kind          = kind_i;
  assign item.motor_select  = motor_select_i;
  assign item.speed         = speed_i;
  assign item.direction     = direction_i;
  assign item.arc_direction = arc_direction_i;
  assign item.arc_radius    = arc_radius_i;

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;

  dmd_ctrl #(
    .MAX_DUTY        (MAX_DUTY),
    .ARC_RADIUS_LIMIT(ARC_RADIUS_LIMIT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .item_i      (item),
    .idle_o      (idle),
    .done_valid_o(done_valid),
    .done_ack_i  (done_ack),
    .result_o    (res)
  );

  // result slot takes a new item once the old one is gone or leaving
  assign done_ack = done_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_ack) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ack) res_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign duty_one_o  = res_q.duty_one;
  assign duty_two_o  = res_q.duty_two;
  assign one_pin_a_o = res_q.pins[0];
  assign one_pin_b_o = res_q.pins[1];
  assign two_pin_a_o = res_q.pins[2];
  assign two_pin_b_o = res_q.pins[3];

endmodule

// ===== design/dmd_cfg_regs.sv =====
// Configuration registers of the motor drive block, trim clamped on write.
// Depends on dmd_pkg.
module dmd_cfg_regs #(
  parameter int unsigned TRIM_LIMIT = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [2:0]    wr_addr_i,
  input  logic [7:0]    wr_data_i,
  output dmd_pkg::cfg_t cfg_o
);

  localparam logic signed [7:0] TrimHi = 8'(TRIM_LIMIT);
  localparam logic signed [7:0] TrimLo = -8'(TRIM_LIMIT);

  dmd_pkg::cfg_t     cfg_q, cfg_d;
  logic signed [7:0] trim_raw;
  logic signed [7:0] trim_cl;

  always_comb begin
    trim_raw = signed'({wr_data_i[6], wr_data_i[6:0]});
    if (trim_raw > TrimHi) begin
      trim_cl = TrimHi;
    end else if (trim_raw < TrimLo) begin
      trim_cl = TrimLo;
    end else begin
      trim_cl = trim_raw;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_addr_i)
        dmd_pkg::REG_FLOOR_SPEED: cfg_d.floor_speed = wr_data_i;
        dmd_pkg::REG_TRIM_ONE:    cfg_d.trim_one    = trim_cl[6:0];
        dmd_pkg::REG_TRIM_TWO:    cfg_d.trim_two    = trim_cl[6:0];
        dmd_pkg::REG_REVERSE_ONE: cfg_d.reverse_one = wr_data_i[0];
        dmd_pkg::REG_REVERSE_TWO: cfg_d.reverse_two = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/dmd_mul.sv =====
// Shared unsigned multiplier with registered product.
// Depends on dmd_pkg for operand widths.
module dmd_mul (
  input  logic                        clk_i,
  input  logic [dmd_pkg::MulAW-1:0]   a_i,
  input  logic [dmd_pkg::MulBW-1:0]   b_i,
  output logic [dmd_pkg::MulPW-1:0]   prod_o
);

  logic [dmd_pkg::MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= dmd_pkg::MulPW'(a_i) * dmd_pkg::MulPW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== design/dmd_ctrl.sv =====
// Command sequencer and datapath: trim, map and arc math on one shared multiplier,
// constant division by reciprocal multiply plus one correction. Depends on dmd_pkg, dmd_mul.
module dmd_ctrl #(
  parameter int unsigned MAX_DUTY         = 255,
  parameter int unsigned ARC_RADIUS_LIMIT = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmd_pkg::cfg_t    cfg_i,
  input  logic             start_i,
  input  dmd_pkg::item_t   item_i,
  output logic             idle_o,
  output logic             done_valid_o,
  input  logic             done_ack_i,
  output dmd_pkg::result_t result_o
);

  localparam logic [7:0]  Max8      = 8'(MAX_DUTY);
  localparam logic [15:0] Max16     = 16'(MAX_DUTY);
  localparam logic [7:0]  MapDiv    = 8'(MAX_DUTY - 1);
  localparam logic [7:0]  RadLim    = 8'(ARC_RADIUS_LIMIT);
  localparam logic [16:0] RecipPct  = 17'((1 << dmd_pkg::RecipShift) / 100);
  localparam logic [16:0] RecipMap  = 17'((1 << dmd_pkg::RecipShift) / (MAX_DUTY - 1));

  localparam int unsigned Sh = dmd_pkg::RecipShift;

  dmd_pkg::ctrl_state_e state_q, state_d;
  dmd_pkg::div_phase_e  phase_q, phase_d;
  dmd_pkg::item_t       item_q, item_d;

  logic [7:0]  duty_one_q, duty_one_d, duty_two_q, duty_two_d;
  logic [3:0]  pins_q, pins_d;
  logic        pend_one_q, pend_one_d, pend_two_q, pend_two_d;
  logic [15:0] spd_one_q, spd_one_d, spd_two_q, spd_two_d;
  logic        dir_one_q, dir_one_d, dir_two_q, dir_two_d;
  logic        motor_q, motor_d;
  logic [7:0]  s1_q, s1_d, s2_q, s2_d, sarc_q, sarc_d;
  logic [15:0] x_q, x_d, q0_q, q0_d, q_q, q_d;
  logic        neg_q, neg_d;

  logic [dmd_pkg::MulAW-1:0] mul_a;
  logic [dmd_pkg::MulBW-1:0] mul_b;
  logic [dmd_pkg::MulPW-1:0] prod;

  logic [7:0]        divisor;
  logic [16:0]       recip;
  logic [15:0]       rem;
  logic [15:0]       spd_sel;
  logic [7:0]        s_cl;
  logic signed [6:0] trim_sel;
  logic              trim_neg;
  logic [6:0]        trim_mag;
  logic              map_neg;
  logic [7:0]        map_mag;
  logic [7:0]        rad_cl;
  logic [8:0]        factor;
  logic signed [17:0] q_s, s1_s, s2_s, m_s, sarc_s;
  logic signed [17:0] tsum, msum, arc_hi, arc_lo;
  logic               bpin;
  logic [7:0]         hi8, lo8;

  function automatic logic [7:0] clamp_duty(logic signed [17:0] v);
    logic [7:0] r;
    if (v < 18'sd1) begin
      r = 8'd1;
    end else if (v > signed'(18'(Max8))) begin
      r = Max8;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  dmd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmd_pkg::ST_IDLE:     if (start_i) state_d = dmd_pkg::ST_DISPATCH;
      dmd_pkg::ST_DISPATCH: begin
        unique case (item_q.kind)
          dmd_pkg::KIND_DRIVE: state_d = dmd_pkg::ST_SELECT;
          dmd_pkg::KIND_ARC: begin
            state_d = (item_q.arc_radius == 8'd0) ? dmd_pkg::ST_SELECT
                                                  : dmd_pkg::ST_ARC_MUL;
          end
          default: state_d = dmd_pkg::ST_DONE;
        endcase
      end
      dmd_pkg::ST_SELECT: begin
        state_d = (pend_one_q || pend_two_q) ? dmd_pkg::ST_TMUL : dmd_pkg::ST_DONE;
      end
      dmd_pkg::ST_TMUL:     state_d = dmd_pkg::ST_DIV_R;
      dmd_pkg::ST_DIV_R:    state_d = dmd_pkg::ST_DIV_B;
      dmd_pkg::ST_DIV_B:    state_d = dmd_pkg::ST_DIV_C;
      dmd_pkg::ST_DIV_C: begin
        unique case (phase_q)
          dmd_pkg::PH_TRIM: state_d = dmd_pkg::ST_TRIM_FIX;
          dmd_pkg::PH_MAP:  state_d = dmd_pkg::ST_MAP_FIX;
          default:          state_d = dmd_pkg::ST_ARC_FIX;
        endcase
      end
      dmd_pkg::ST_TRIM_FIX: state_d = dmd_pkg::ST_MMUL;
      dmd_pkg::ST_MMUL:     state_d = dmd_pkg::ST_DIV_R;
      dmd_pkg::ST_MAP_FIX:  state_d = dmd_pkg::ST_SELECT;
      dmd_pkg::ST_ARC_MUL:  state_d = dmd_pkg::ST_DIV_R;
      dmd_pkg::ST_ARC_FIX:  state_d = dmd_pkg::ST_SELECT;
      dmd_pkg::ST_DONE:     if (done_ack_i) state_d = dmd_pkg::ST_IDLE;
      default:              state_d = dmd_pkg::ST_IDLE;
    endcase
  end

  // Shared terms
  always_comb begin
    divisor  = (phase_q == dmd_pkg::PH_MAP) ? MapDiv : dmd_pkg::PctDiv;
    recip    = (phase_q == dmd_pkg::PH_MAP) ? RecipMap : RecipPct;
    rem      = x_q - prod[15:0];

    spd_sel  = pend_one_q ? spd_one_q : spd_two_q;
    if (spd_sel == 16'd0) begin
      s_cl = 8'd1;
    end else if (spd_sel > Max16) begin
      s_cl = Max8;
    end else begin
      s_cl = spd_sel[7:0];
    end
    if ((cfg_i.floor_speed != 8'd0) && (s_cl < cfg_i.floor_speed)) begin
      s_cl = cfg_i.floor_speed;
    end

    trim_sel = motor_q ? cfg_i.trim_two : cfg_i.trim_one;
    trim_neg = trim_sel[6];
    trim_mag = trim_neg ? 7'(-trim_sel) : 7'(trim_sel);

    map_neg  = cfg_i.floor_speed > Max8;
    map_mag  = map_neg ? (cfg_i.floor_speed - Max8) : (Max8 - cfg_i.floor_speed);

    rad_cl   = (item_q.arc_radius > RadLim) ? RadLim : item_q.arc_radius;
    factor   = (9'(RadLim) + 9'd1 - 9'(rad_cl)) << 1;

    q_s      = signed'({2'b00, q_q});
    s1_s     = signed'({10'd0, s1_q});
    s2_s     = signed'({10'd0, s2_q});
    m_s      = signed'({10'd0, cfg_i.floor_speed});
    sarc_s   = signed'({10'd0, sarc_q});
    tsum     = neg_q ? (s1_s - q_s) : (s1_s + q_s);
    msum     = neg_q ? (m_s - q_s) : (m_s + q_s);
    arc_hi   = sarc_s + q_s;
    arc_lo   = sarc_s - q_s;
    hi8      = clamp_duty(arc_hi);
    lo8      = clamp_duty(arc_lo);
    bpin     = motor_q ? (dir_two_q ^ cfg_i.reverse_two) : (dir_one_q ^ cfg_i.reverse_one);
  end

  // Datapath and multiplier operands
  always_comb begin
    item_d     = item_q;
    phase_d    = phase_q;
    duty_one_d = duty_one_q;
    duty_two_d = duty_two_q;
    pins_d     = pins_q;
    pend_one_d = pend_one_q;
    pend_two_d = pend_two_q;
    spd_one_d  = spd_one_q;
    spd_two_d  = spd_two_q;
    dir_one_d  = dir_one_q;
    dir_two_d  = dir_two_q;
    motor_d    = motor_q;
    s1_d       = s1_q;
    s2_d       = s2_q;
    sarc_d     = sarc_q;
    x_d        = x_q;
    q0_d       = q0_q;
    q_d        = q_q;
    neg_d      = neg_q;
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_q)
      dmd_pkg::ST_IDLE: begin
        if (start_i) item_d = item_i;
      end
      dmd_pkg::ST_DISPATCH: begin
        unique case (item_q.kind)
          dmd_pkg::KIND_DRIVE: begin
            pend_one_d = (item_q.motor_select == dmd_pkg::SEL_ONE) ||
                         (item_q.motor_select == dmd_pkg::SEL_BOTH);
            pend_two_d = (item_q.motor_select == dmd_pkg::SEL_TWO) ||
                         (item_q.motor_select == dmd_pkg::SEL_BOTH);
            spd_one_d  = item_q.speed;
            spd_two_d  = item_q.speed;
            dir_one_d  = item_q.direction;
            dir_two_d  = item_q.direction;
          end
          dmd_pkg::KIND_ARC: begin
            sarc_d = (item_q.speed > Max16) ? Max8 : item_q.speed[7:0];
            if (item_q.arc_radius == 8'd0) begin
              // spin in place
              pend_one_d = 1'b1;
              pend_two_d = 1'b1;
              spd_one_d  = (item_q.speed > Max16) ? Max16 : item_q.speed;
              spd_two_d  = (item_q.speed > Max16) ? Max16 : item_q.speed;
              dir_one_d  = item_q.arc_direction;
              dir_two_d  = ~item_q.arc_direction;
            end
          end
          dmd_pkg::KIND_STOP: begin
            if ((item_q.motor_select == dmd_pkg::SEL_ONE) ||
                (item_q.motor_select == dmd_pkg::SEL_BOTH)) begin
              pins_d[1:0] = 2'b00;
            end
            if ((item_q.motor_select == dmd_pkg::SEL_TWO) ||
                (item_q.motor_select == dmd_pkg::SEL_BOTH)) begin
              pins_d[3:2] = 2'b00;
            end
          end
          default: ;
        endcase
      end
      dmd_pkg::ST_SELECT: begin
        s1_d    = s_cl;
        motor_d = ~pend_one_q;
        if (pend_one_q) begin
          pend_one_d = 1'b0;
        end else begin
          pend_two_d = 1'b0;
        end
      end
      dmd_pkg::ST_TMUL: begin
        mul_a   = dmd_pkg::MulAW'(s1_q);
        mul_b   = dmd_pkg::MulBW'(trim_mag);
        neg_d   = trim_neg;
        phase_d = dmd_pkg::PH_TRIM;
      end
      dmd_pkg::ST_DIV_R: begin
        x_d   = prod[15:0];
        mul_a = prod[15:0];
        mul_b = recip;
      end
      dmd_pkg::ST_DIV_B: begin
        q0_d  = prod[Sh+15:Sh];
        mul_a = prod[Sh+15:Sh];
        mul_b = dmd_pkg::MulBW'(divisor);
      end
      dmd_pkg::ST_DIV_C: begin
        // estimate is at most one low
        q_d = q0_q + 16'(rem >= 16'(divisor));
      end
      dmd_pkg::ST_TRIM_FIX: begin
        s2_d = clamp_duty(tsum);
      end
      dmd_pkg::ST_MMUL: begin
        mul_a   = dmd_pkg::MulAW'(s2_q - 8'd1);
        mul_b   = dmd_pkg::MulBW'(map_mag);
        neg_d   = map_neg;
        phase_d = dmd_pkg::PH_MAP;
      end
      dmd_pkg::ST_MAP_FIX: begin
        if (motor_q) begin
          duty_two_d  = msum[7:0];
          pins_d[3:2] = {bpin, ~bpin};
        end else begin
          duty_one_d  = msum[7:0];
          pins_d[1:0] = {bpin, ~bpin};
        end
      end
      dmd_pkg::ST_ARC_MUL: begin
        mul_a   = dmd_pkg::MulAW'(sarc_q);
        mul_b   = dmd_pkg::MulBW'(factor);
        phase_d = dmd_pkg::PH_ARC;
      end
      dmd_pkg::ST_ARC_FIX: begin
        pend_one_d = 1'b1;
        pend_two_d = 1'b1;
        spd_one_d  = 16'(item_q.arc_direction ? lo8 : hi8);
        spd_two_d  = 16'(item_q.arc_direction ? hi8 : lo8);
        dir_one_d  = 1'b0;
        dir_two_d  = 1'b0;
      end
      dmd_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dmd_pkg::ST_IDLE;
      duty_one_q <= '0;
      duty_two_q <= '0;
      pins_q     <= '0;
      pend_one_q <= 1'b0;
      pend_two_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      duty_one_q <= duty_one_d;
      duty_two_q <= duty_two_d;
      pins_q     <= pins_d;
      pend_one_q <= pend_one_d;
      pend_two_q <= pend_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    phase_q   <= phase_d;
    spd_one_q <= spd_one_d;
    spd_two_q <= spd_two_d;
    dir_one_q <= dir_one_d;
    dir_two_q <= dir_two_d;
    motor_q   <= motor_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    sarc_q    <= sarc_d;
    x_q       <= x_d;
    q0_q      <= q0_d;
    q_q       <= q_d;
    neg_q     <= neg_d;
  end

  assign idle_o            = (state_q == dmd_pkg::ST_IDLE);
  assign done_valid_o      = (state_q == dmd_pkg::ST_DONE);
  assign result_o.duty_one = duty_one_q;
  assign result_o.duty_two = duty_two_q;
  assign result_o.pins     = pins_q;

endmodule
